[rtl/core/v3alu_pkg.sv]
// ---------------------------------------------------------------------------
// v3alu_pkg
// Types, constants and rounding helpers for the three-component vector ALU.
// ---------------------------------------------------------------------------
package v3alu_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int NORM_EPS_DIV = 100000;
  // rounded norm must exceed this to normalize (1e-5 in fixed point, truncates to zero)
  localparam logic [32:0] NORM_THR = 33'((64'd1 << FRAC_BITS) / NORM_EPS_DIV);
  localparam int SQ_STEPS = 32;               // root bits, one per stage
  localparam int QBITS    = 33;               // quotient bits kept by divider
  localparam int NUM_W    = QBITS + FRAC_BITS; // dividend width

  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_SUB       = 3'd1,
    OP_DOT       = 3'd2,
    OP_CROSS     = 3'd3,
    OP_SCALE     = 3'd4,
    OP_DIVIDE    = 3'd5,
    OP_NORM      = 3'd6,
    OP_NORMALIZE = 3'd7
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;
  } req_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_out;
    logic               saturated;
    logic               div_zero;
  } res_t;

  // request context carried down the pipe, with results filled in as known
  typedef struct packed {
    op_t              op;
    logic [2:0][31:0] a;
    logic [31:0]      s;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             sat;
    logic             dz;
  } ctx_t;

  typedef struct packed {
    ctx_t        c;
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sq_t;

  typedef struct packed {
    ctx_t                   c;
    logic                   use_div;
    logic [33:0]            d;
    logic [2:0][33:0]       rem;
    logic [2:0][QBITS-1:0]  nb;
    logic [2:0][QBITS-1:0]  q;
    logic [2:0]             ovf;
    logic [2:0]             neg;
  } dv_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat32_t;

  // round half up at the binary point, then clip to 32 bits
  function automatic sat32_t round_sat(input logic signed [65:0] v);
    logic signed [65:0] w;
    sat32_t o;
    w = (v + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    o.sat = (w[65:31] != {35{w[31]}});
    o.val = o.sat ? (w[65] ? 32'h8000_0000 : 32'h7FFF_FFFF) : w[31:0];
    return o;
  endfunction

  // signed quotient from magnitude, sign and overflow flag
  function automatic sat32_t quot_sat(input logic [QBITS-1:0] q, input logic ovf,
                                      input logic neg);
    sat32_t o;
    if (neg) begin
      o.sat = ovf || (q > QBITS'(33'h0_8000_0000));
      o.val = o.sat ? 32'h8000_0000 : 32'(~q + 1'b1);
    end else begin
      o.sat = ovf || (q > QBITS'(33'h0_7FFF_FFFF));
      o.val = o.sat ? 32'h7FFF_FFFF : q[31:0];
    end
    return o;
  endfunction

endpackage

[rtl/core/vector3_alu_unit.sv]
// ---------------------------------------------------------------------------
// vector3_alu_unit
// Pipelined Q16.16 vector ALU: add, sub, dot, cross, scale, divide, norm,
// normalize.
// ---------------------------------------------------------------------------
// One request enters per cycle unless the pipe is stalled. The pipe holds
// three stages of operand register, six 32x32 multipliers and product sums,
// a product-rounding stage, a 32-stage square root (one root bit per stage),
// a divider-setup stage, a 33-stage divider (one quotient bit per stage,
// three lanes) and an output register. Every op walks the full pipe.
// Back-pressure on res stalls the whole pipe at once; req_ready follows it.
module vector3_alu_unit
  import v3alu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic en;
  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  // ---------------- stage 1: operand register ----------------
  logic             v1;
  ctx_t             c1;
  logic [2:0][31:0] b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1.op  <= req.op;
      c1.a   <= {req.a_z, req.a_y, req.a_x};
      c1.s   <= req.scalar_in;
      c1.r   <= '0;
      c1.sc  <= '0;
      c1.sat <= 1'b0;
      c1.dz  <= 1'b0;
      b1     <= {req.b_z, req.b_y, req.b_x};
    end
  end

  // ---------------- stage 2: multipliers, add/sub ----------------
  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];
  logic [32:0]        as_sum [3];
  ctx_t               c2_next;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    case (c1.op)
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = c1.a[i];
          mb[i] = b1[i];
        end
      end
      OP_CROSS: begin
        ma[0] = c1.a[1]; mb[0] = b1[2];
        ma[1] = c1.a[2]; mb[1] = b1[1];
        ma[2] = c1.a[2]; mb[2] = b1[0];
        ma[3] = c1.a[0]; mb[3] = b1[2];
        ma[4] = c1.a[0]; mb[4] = b1[1];
        ma[5] = c1.a[1]; mb[5] = b1[0];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = c1.a[i];
          mb[i] = c1.s;
        end
      end
      OP_NORM, OP_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          ma[i] = c1.a[i];
          mb[i] = c1.a[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    c2_next = c1;
    for (int i = 0; i < 3; i++) begin
      if (c1.op == OP_SUB) begin
        as_sum[i] = 33'($signed(c1.a[i])) - 33'($signed(b1[i]));
      end else begin
        as_sum[i] = 33'($signed(c1.a[i])) + 33'($signed(b1[i]));
      end
      if (c1.op == OP_ADD || c1.op == OP_SUB) begin
        if (as_sum[i][32] != as_sum[i][31]) begin
          c2_next.sat  = 1'b1;
          c2_next.r[i] = as_sum[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          c2_next.r[i] = as_sum[i][31:0];
        end
      end
    end
  end

  logic             v2;
  ctx_t             c2;
  logic [5:0][63:0] p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c2_next;
      for (int i = 0; i < 6; i++) begin
        p2[i] <= 64'(ma[i] * mb[i]);
      end
    end
  end

  // ---------------- stage 3: exact sums ----------------
  logic signed [65:0] pe [6];
  logic [2:0][65:0]   v3_next;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      pe[i] = 66'($signed(p2[i]));
    end
    v3_next = '0;
    case (c2.op)
      OP_DOT: v3_next[0] = pe[0] + pe[1] + pe[2];
      OP_CROSS: begin
        v3_next[0] = pe[0] - pe[1];
        v3_next[1] = pe[2] - pe[3];
        v3_next[2] = pe[4] - pe[5];
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          v3_next[i] = pe[i];
        end
      end
    endcase
  end

  logic             v3;
  ctx_t             c3;
  logic [2:0][65:0] s3;
  logic [63:0]      sq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3  <= c2;
      s3  <= v3_next;
      sq3 <= p2[0] + p2[1] + p2[2];
    end
  end

  // ---------------- stage 4: round products, start root ----------------
  sq_t    sq   [0:SQ_STEPS];
  logic   sq_v [0:SQ_STEPS];
  sq_t    sq0_next;
  sat32_t rs   [3];

  always_comb begin
    sq0_next      = '0;
    sq0_next.c    = c3;
    sq0_next.rad  = sq3;
    for (int i = 0; i < 3; i++) begin
      rs[i] = round_sat(s3[i]);
    end
    case (c3.op)
      OP_DOT: begin
        sq0_next.c.sc  = rs[0].val;
        sq0_next.c.sat = rs[0].sat;
      end
      OP_CROSS, OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          sq0_next.c.r[i] = rs[i].val;
        end
        sq0_next.c.sat = rs[0].sat || rs[1].sat || rs[2].sat;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0] <= sq0_next;
    end
  end

  // ---------------- square root, one bit per stage ----------------
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;
    sq_t         nxt;

    always_comb begin
      cur      = {sq[k].rem, sq[k].rad[63:62]};
      trial    = {2'b00, sq[k].root, 2'b01};
      ge       = (cur >= trial);
      nxt      = sq[k];
      nxt.rem  = ge ? 34'(cur - trial) : cur[33:0];
      nxt.root = {sq[k].root[30:0], ge};
      nxt.rad  = {sq[k].rad[61:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[k+1] <= nxt;
      end
    end
  end

  // ---------------- root rounding, divider setup ----------------
  dv_t                  dv   [0:QBITS];
  logic                 dv_v [0:QBITS];
  dv_t                  dv0_next;
  logic [32:0]          nrm;
  logic [32:0]          den;
  logic                 dneg;
  logic [31:0]          mag  [3];
  logic [NUM_W-1:0]     num  [3];
  ctx_t                 cs;

  always_comb begin
    cs   = sq[SQ_STEPS].c;
    nrm  = {1'b0, sq[SQ_STEPS].root}
         + 33'(sq[SQ_STEPS].rem > {2'b00, sq[SQ_STEPS].root});
    den  = '0;
    dneg = 1'b0;
    dv0_next         = '0;
    dv0_next.c       = cs;
    dv0_next.use_div = 1'b0;
    case (cs.op)
      OP_NORM: begin
        dv0_next.c.sat = (nrm[32:31] != 2'b00);
        dv0_next.c.sc  = dv0_next.c.sat ? 32'h7FFF_FFFF : nrm[31:0];
      end
      OP_NORMALIZE: begin
        if (nrm > NORM_THR) begin
          dv0_next.use_div = 1'b1;
          den              = nrm;
        end else begin
          dv0_next.c.r = cs.a;
        end
      end
      OP_DIVIDE: begin
        if (cs.s == '0) begin
          dv0_next.c.dz = 1'b1;
        end else begin
          dv0_next.use_div = 1'b1;
          dneg             = cs.s[31];
          den              = cs.s[31] ? 33'(~{cs.s[31], cs.s} + 1'b1) : {1'b0, cs.s};
        end
      end
      default: begin
      end
    endcase
    dv0_next.d = {den, 1'b0};
    // dividend is |a| * 2^(F+1) + den, giving a quotient rounded to nearest
    for (int i = 0; i < 3; i++) begin
      mag[i] = cs.a[i][31] ? (~cs.a[i] + 1'b1) : cs.a[i];
      num[i] = (NUM_W'(mag[i]) << (FRAC_BITS + 1)) + NUM_W'(den);
      dv0_next.ovf[i] = (34'(num[i][NUM_W-1:QBITS]) >= dv0_next.d);
      dv0_next.rem[i] = dv0_next.ovf[i] ? 34'd0 : 34'(num[i][NUM_W-1:QBITS]);
      dv0_next.nb[i]  = num[i][QBITS-1:0];
      dv0_next.neg[i] = cs.a[i][31] ^ dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv0_next;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  for (genvar k = 0; k < QBITS; k++) begin : g_dv
    logic [34:0] cur [3];
    logic [2:0]  ge;
    dv_t         nxt;

    always_comb begin
      nxt = dv[k];
      for (int i = 0; i < 3; i++) begin
        cur[i]     = {dv[k].rem[i], dv[k].nb[i][QBITS-1]};
        ge[i]      = (cur[i] >= {1'b0, dv[k].d});
        nxt.rem[i] = ge[i] ? 34'(cur[i] - {1'b0, dv[k].d}) : cur[i][33:0];
        nxt.q[i]   = {dv[k].q[i][QBITS-2:0], ge[i]};
        nxt.nb[i]  = {dv[k].nb[i][QBITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= nxt;
      end
    end
  end

  // ---------------- output register ----------------
  sat32_t qs [3];
  res_t   res_next;
  dv_t    dl;

  always_comb begin
    dl = dv[QBITS];
    for (int i = 0; i < 3; i++) begin
      qs[i] = quot_sat(dl.q[i], dl.ovf[i], dl.neg[i]);
    end
    res_next.r_x        = dl.c.r[0];
    res_next.r_y        = dl.c.r[1];
    res_next.r_z        = dl.c.r[2];
    res_next.scalar_out = dl.c.sc;
    res_next.saturated  = dl.c.sat;
    res_next.div_zero   = dl.c.dz;
    if (dl.use_div) begin
      res_next.r_x       = qs[0].val;
      res_next.r_y       = qs[1].val;
      res_next.r_z       = qs[2].val;
      res_next.saturated = qs[0].sat || qs[1].sat || qs[2].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= dv_v[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  // ---------------- assertions ----------------
  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.div_zero |->
      (res.r_x == 0 && res.r_y == 0 && res.r_z == 0 && !res.saturated))
    else $error("div_zero result carries data or saturation");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQ_STEPS] |-> (sq[SQ_STEPS].rem <= {1'b0, sq[SQ_STEPS].root, 1'b0}))
    else $error("square root remainder out of bound");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    dv_v[QBITS] && dv[QBITS].use_div |->
      ((dv[QBITS].ovf[0] || dv[QBITS].rem[0] < dv[QBITS].d) &&
       (dv[QBITS].ovf[1] || dv[QBITS].rem[1] < dv[QBITS].d) &&
       (dv[QBITS].ovf[2] || dv[QBITS].rem[2] < dv[QBITS].d)))
    else $error("divider remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_v[QBITS]) && $stable(sq_v[SQ_STEPS]))
    else $error("pipe moved during stall");

endmodule

[tb/vector3_alu_unit_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector3_alu_unit_checker
// Watches the request and result channels of the vector ALU, computes the
// expected result of every accepted request and compares it in order with
// the results that leave the block.
// ---------------------------------------------------------------------------
module vector3_alu_unit_checker
  import v3alu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res,
  output int   errors,
  output int   pending
);

  typedef logic signed [127:0] wide_t;

  res_t expected_q[$];

  initial errors = 0;
  assign pending = expected_q.size();

  task automatic report(input string msg);
    $display("vector3_alu_unit_checker: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [31:0] clip32(input wide_t v, inout logic sat);
    if (v > wide_t'(32'sh7FFF_FFFF)) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -wide_t'(64'sh8000_0000)) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // exact product sum, round half up, then clip
  function automatic logic [31:0] round_clip(input wide_t p, inout logic sat);
    return clip32((p + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS, sat);
  endfunction

  // fixed-point quotient, nearest with ties away from zero
  function automatic logic [31:0] quot_clip(input wide_t a, input wide_t den,
                                            input logic den_neg, inout logic sat);
    wide_t mag, num, q;
    mag = (a < 0) ? -a : a;
    num = mag <<< FRAC_BITS;
    q = (2 * num + den) / (2 * den);
    return clip32(((a < 0) != den_neg) ? -q : q, sat);
  endfunction

  function automatic logic [63:0] root_rounded(input logic [63:0] n);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (n > root) root += 1;
    return root;
  endfunction

  function automatic res_t alu_result(input req_t q);
    wide_t a[3], b[3], s, n;
    logic [31:0] r[3];
    logic [31:0] sc;
    logic sat, dz;
    logic [63:0] sq;
    a[0] = $signed(q.a_x); a[1] = $signed(q.a_y); a[2] = $signed(q.a_z);
    b[0] = $signed(q.b_x); b[1] = $signed(q.b_y); b[2] = $signed(q.b_z);
    s = $signed(q.scalar_in);
    r[0] = '0; r[1] = '0; r[2] = '0;
    sc = '0; sat = 1'b0; dz = 1'b0;
    sq = 64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    n = wide_t'(root_rounded(sq));
    case (q.op)
      OP_ADD:   for (int i = 0; i < 3; i++) r[i] = clip32(a[i] + b[i], sat);
      OP_SUB:   for (int i = 0; i < 3; i++) r[i] = clip32(a[i] - b[i], sat);
      OP_DOT:   sc = round_clip(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], sat);
      OP_CROSS: begin
        r[0] = round_clip(a[1] * b[2] - a[2] * b[1], sat);
        r[1] = round_clip(a[2] * b[0] - a[0] * b[2], sat);
        r[2] = round_clip(a[0] * b[1] - a[1] * b[0], sat);
      end
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = round_clip(a[i] * s, sat);
      OP_DIVIDE: begin
        if (s == 0) dz = 1'b1;
        else for (int i = 0; i < 3; i++)
          r[i] = quot_clip(a[i], (s < 0) ? -s : s, s < 0, sat);
      end
      OP_NORM:  sc = clip32(n, sat);
      default: begin
        if (n > wide_t'(NORM_THR)) begin
          for (int i = 0; i < 3; i++) r[i] = quot_clip(a[i], n, 1'b0, sat);
        end else begin
          for (int i = 0; i < 3; i++) r[i] = a[i][31:0];
        end
      end
    endcase
    return '{r_x: r[0], r_y: r[1], r_z: r[2], scalar_out: sc,
             saturated: sat, div_zero: dz};
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (expected_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          e = expected_q.pop_front();
          if (res.r_x !== e.r_x)
            report($sformatf("r_x %h, expected %h", res.r_x, e.r_x));
          if (res.r_y !== e.r_y)
            report($sformatf("r_y %h, expected %h", res.r_y, e.r_y));
          if (res.r_z !== e.r_z)
            report($sformatf("r_z %h, expected %h", res.r_z, e.r_z));
          if (res.scalar_out !== e.scalar_out)
            report($sformatf("scalar_out %h, expected %h", res.scalar_out, e.scalar_out));
          if (res.saturated !== e.saturated)
            report($sformatf("saturated %b, expected %b", res.saturated, e.saturated));
          if (res.div_zero !== e.div_zero)
            report($sformatf("div_zero %b, expected %b", res.div_zero, e.div_zero));
        end
      end
      if (req_valid && req_ready) expected_q.push_back(alu_result(req));
    end
  end

endmodule

[tb/vector3_alu_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vector3_alu_unit_tb
// Drives directed and random requests through the vector ALU with random
// gaps and result back-pressure, including one long stall that freezes the
// whole pipe; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module vector3_alu_unit_tb
  import v3alu_pkg::*;
();

  localparam int N_RANDOM = 830;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic res_valid;
  logic res_ready;
  res_t res;
  int   errors;
  int   pending;
  bit   send_burst;
  bit   recv_burst;

  always #2 clk = ~clk;

  vector3_alu_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  vector3_alu_unit_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .errors    (errors),
    .pending   (pending)
  );

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      1: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      2: case ($urandom_range(0, 4))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0000_0000;
           3: return 32'h0000_0001;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t make_req(input op_t op, input logic [31:0] ax, ay, az,
                                    bx, by, bz, s);
    return '{op: op, a_x: ax, a_y: ay, a_z: az, b_x: bx, b_y: by, b_z: bz,
             scalar_in: s};
  endfunction

  // present one request and hold it until taken
  task automatic send(input req_t r);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // result side: random stalls, bursts, and one long hold-off
  initial begin
    int gap;
    int taken;
    res_ready = 1'b0;
    taken = 0;
    @(negedge rst);
    forever begin
      if (taken % 64 == 0) recv_burst = ($urandom_range(0, 2) == 0);
      gap = recv_burst ? 0 : $urandom_range(0, 10);
      if (taken == 150) gap = 400;
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    #2ms;
    $display("vector3_alu_unit_tb: FAIL");
    $finish;
  end

  initial begin
    req_t r;
    logic [31:0] mx, mn, one;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    one = 32'h0001_0000;
    send_burst = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, each op, saturation, zero divisor, tiny norm
    send(make_req(OP_ADD, mx, mn, one, one, mn, 32'hFFFF_0000, 0));
    send(make_req(OP_SUB, mn, mx, 0, one, mn, 32'hFFFF_FFFF, mx));
    send(make_req(OP_DOT, one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one, 0));
    send(make_req(OP_DOT, mx, mx, mx, mx, mx, mx, 0));
    send(make_req(OP_DOT, mn, mn, mn, mx, mx, mx, 0));
    send(make_req(OP_DOT, 32'h0000_8000, 0, 0, 1, 0, 0, 0));
    send(make_req(OP_DOT, 32'hFFFF_8000, 0, 0, 1, 0, 0, 0));
    send(make_req(OP_CROSS, one, 0, 0, 0, one, 0, 0));
    send(make_req(OP_CROSS, mn, mx, mn, mx, mn, mx, 0));
    send(make_req(OP_SCALE, mx, mn, 32'h0000_8000, 0, 0, 0, 32'h0000_8000));
    send(make_req(OP_SCALE, 32'hFFFF_FFFF, 1, 3, 0, 0, 0, 32'h0000_8000));
    send(make_req(OP_SCALE, mx, mn, one, 0, 0, 0, mn));
    send(make_req(OP_DIVIDE, one, mn, mx, 0, 0, 0, 0));
    send(make_req(OP_DIVIDE, one, 3 * one, mn, 0, 0, 0, 2 * one));
    send(make_req(OP_DIVIDE, mx, mn, 1, 0, 0, 0, 1));
    send(make_req(OP_DIVIDE, mn, 3, 32'hFFFF_FFFD, 0, 0, 0, 32'hFFFF_FFFE));
    send(make_req(OP_DIVIDE, one, mn, mx, 0, 0, 0, mn));
    send(make_req(OP_NORM, 3 * one, 4 * one, 0, 0, 0, 0, 0));
    send(make_req(OP_NORM, mn, mn, mn, 0, 0, 0, 0));
    send(make_req(OP_NORM, 0, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_NORMALIZE, 0, 0, 0, mx, mn, 1, mx));
    send(make_req(OP_NORMALIZE, 1, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_NORMALIZE, 3 * one, 32'hFFFC_0000, 0, 0, 0, 0, 0));
    send(make_req(OP_NORMALIZE, mn, mx, mn, 0, 0, 0, 0));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) send_burst = ($urandom_range(0, 2) == 0);
      r = make_req(op_t'($urandom_range(0, 7)), pick_val(), pick_val(), pick_val(),
                   pick_val(), pick_val(), pick_val(), pick_val());
      if (r.op == OP_DIVIDE && $urandom_range(0, 7) == 0) r.scalar_in = '0;
      if (r.op == OP_NORMALIZE && $urandom_range(0, 7) == 0) begin
        r.a_x = '0;
        r.a_y = '0;
        r.a_z = '0;
      end
      send(r);
    end
    req_valid <= 1'b0;
    @(negedge clk);

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("vector3_alu_unit_tb: PASS");
    end else begin
      $display("vector3_alu_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/v3alu_pkg.sv
rtl/core/vector3_alu_unit.sv
tb/vector3_alu_unit_checker.sv
tb/vector3_alu_unit_tb.sv
